@@ rtl/core/hse_pkg.sv @@
// Package for the hall sensor emulator with PWM output.
// Register indexes, reset values, the reciprocal of three, phase codes and the six-step latch pattern.
// No dependencies.
`default_nettype none

package hse_pkg;

	localparam int COUNT_WIDTH_DEFAULT = 16;
	localparam int CFG_WIDTH           = 16;
	localparam int CFG_INDEX_WIDTH     = 2;
	localparam int PHASE_WIDTH         = 3;

	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_HALL_CYCLE = 2'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PWM_CYCLE  = 2'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PWM_HIGH   = 2'd2;

	localparam logic [CFG_WIDTH-1:0] HALL_CYCLE_RESET = 16'd9960;
	localparam logic [CFG_WIDTH-1:0] PWM_CYCLE_RESET  = 16'd100;
	localparam logic [CFG_WIDTH-1:0] PWM_HIGH_RESET   = 16'd20;
	// Third of the reset hall period, kept alongside it
	localparam logic [CFG_WIDTH-1:0] HALL_THIRD_RESET = 16'd3320;

	// Reciprocal of three for 16-bit operands: floor(x * RECIP3 / 2^17) = x / 3
	localparam logic [CFG_WIDTH:0] RECIP3       = 17'd43691;
	localparam int                 RECIP3_SHIFT = 17;

	typedef logic [PHASE_WIDTH-1:0] phase_t;

	localparam phase_t PHASE_0 = 3'd0;
	localparam phase_t PHASE_1 = 3'd1;
	localparam phase_t PHASE_2 = 3'd2;
	localparam phase_t PHASE_3 = 3'd3;
	localparam phase_t PHASE_4 = 3'd4;
	localparam phase_t PHASE_5 = 3'd5;

	// Hall lines latched on leaving a phase: bit0 A, bit1 B, bit2 C
	function automatic logic [2:0] hall_latch(input phase_t ph);
		logic [2:0] lines;
		unique case (ph)
			PHASE_0: lines = 3'b001;
			PHASE_1: lines = 3'b011;
			PHASE_2: lines = 3'b010;
			PHASE_3: lines = 3'b110;
			PHASE_4: lines = 3'b100;
			default: lines = 3'b101;
		endcase
		return lines;
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/hall_sensor_emulator_pwm.sv @@
// Six-step hall sensor emulator with PWM output: top level.
// The result word is registered: it is valid right after the edge that accepts its tick word.
// Throughput one word per cycle while out_ready is high; counter and phase logic is combinational.
// Reset (arst_n low, asynchronous): counters 0, phase 5, hall and PWM lines low,
// registers at 9960 / 100 / 20; no result word pending.
// Depends on hse_pkg.
`default_nettype none

module hall_sensor_emulator_pwm #(
	parameter int COUNT_WIDTH = hse_pkg::COUNT_WIDTH_DEFAULT
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// Tick channel
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic                                advance,
	// Result channel
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic                                     pwm_level,
	output logic                                     hall_a,
	output logic                                     hall_b,
	output logic                                     hall_c,
	output logic [hse_pkg::PHASE_WIDTH-1:0]          phase_now,
	// Configuration write channel
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [hse_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  wire logic [hse_pkg::CFG_WIDTH-1:0]       cfg_data
);

	// Width that holds both a count and a 16-bit period for compares
	localparam int XW = (COUNT_WIDTH > hse_pkg::CFG_WIDTH) ? COUNT_WIDTH : hse_pkg::CFG_WIDTH;
	localparam int CW = hse_pkg::CFG_WIDTH;
	localparam int PW = CW + CW + 1;

	// Configuration registers
	logic [CW-1:0] hall_cycle_q;
	logic [CW-1:0] pwm_cycle_q;
	logic [CW-1:0] pwm_high_q;
	// Third of the hall period, worked out when the period is written
	logic [CW-1:0] hall_third_q;

	// Block state; the result word is read straight from it
	logic [COUNT_WIDTH-1:0] pwm_count_q;
	logic [COUNT_WIDTH-1:0] hall_count_q;
	hse_pkg::phase_t        phase_q;
	logic [2:0]             hall_lines_q;
	logic                   pwm_line_q;
	logic                   out_valid_q;

	logic                   in_accept;
	logic                   tick;
	logic [PW-1:0]          third_prod;
	logic [COUNT_WIDTH-1:0] pwm_inc;
	logic [COUNT_WIDTH-1:0] hall_inc;
	logic [COUNT_WIDTH-1:0] pwm_next;
	logic [COUNT_WIDTH-1:0] hall_next;
	logic [CW-1:0]          threshold;
	logic [XW-1:0]          cmp_wide;
	logic [COUNT_WIDTH-1:0] cmp_value;
	logic                   phase_step;

	// Config writes never stall
	assign cfg_ready = 1'b1;

	// x / 3 by reciprocal multiply; exact over the full 16-bit range
	assign third_prod = PW'(cfg_data) * PW'(hse_pkg::RECIP3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hall_cycle_q <= hse_pkg::HALL_CYCLE_RESET;
			pwm_cycle_q  <= hse_pkg::PWM_CYCLE_RESET;
			pwm_high_q   <= hse_pkg::PWM_HIGH_RESET;
			hall_third_q <= hse_pkg::HALL_THIRD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				hse_pkg::CFG_HALL_CYCLE: begin
					hall_cycle_q <= cfg_data;
					hall_third_q <= third_prod[hse_pkg::RECIP3_SHIFT +: CW];
				end
				hse_pkg::CFG_PWM_CYCLE: pwm_cycle_q <= cfg_data;
				hse_pkg::CFG_PWM_HIGH:  pwm_high_q  <= cfg_data;
				default: ; // drop writes beyond the register list
			endcase
		end
	end

	// Take a new word whenever the result slot is empty or being drained this cycle
	assign in_ready  = !out_valid_q || out_ready;
	assign in_accept = in_valid && in_ready;
	assign tick      = in_accept && advance;

	// Pre-increment with natural wrap, then clear once the period is reached
	assign pwm_inc   = pwm_count_q + 1'b1;
	assign hall_inc  = hall_count_q + 1'b1;
	assign pwm_next  = (XW'(pwm_inc) >= XW'(pwm_cycle_q)) ? '0 : pwm_inc;
	assign hall_next = (XW'(hall_inc) >= XW'(hall_cycle_q)) ? '0 : hall_inc;

	// Phase thresholds from P, P/2, P/3 and P/6 = (P/3)/2
	always_comb begin
		unique case (phase_q)
			hse_pkg::PHASE_0: threshold = hall_third_q >> 1;
			hse_pkg::PHASE_1: threshold = hall_third_q;
			hse_pkg::PHASE_2: threshold = hall_cycle_q >> 1;
			hse_pkg::PHASE_3: threshold = hall_third_q << 1;
			hse_pkg::PHASE_4: threshold = (hall_cycle_q >> 1) + hall_third_q;
			default:          threshold = hall_cycle_q;
		endcase
	end

	// A zero threshold wraps to all ones and the phase never steps
	assign cmp_wide   = XW'(threshold) - 1'b1;
	assign cmp_value  = cmp_wide[COUNT_WIDTH-1:0];
	assign phase_step = (hall_next == cmp_value);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pwm_count_q  <= '0;
			hall_count_q <= '0;
			phase_q      <= hse_pkg::PHASE_5;
			hall_lines_q <= '0;
			pwm_line_q   <= 1'b0;
		end else if (tick) begin
			pwm_count_q  <= pwm_next;
			pwm_line_q   <= (XW'(pwm_next) < XW'(pwm_high_q));
			hall_count_q <= hall_next;
			if (phase_step) begin
				hall_lines_q <= hse_pkg::hall_latch(phase_q);
				phase_q      <= (phase_q == hse_pkg::PHASE_5) ? hse_pkg::PHASE_0
				                : hse_pkg::phase_t'(phase_q + 1'b1);
			end
		end
	end

	// Every accepted word yields one result word; hold it until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// State only moves on an accept, so it stays put while a result waits
	assign out_valid = out_valid_q;
	assign pwm_level = pwm_line_q;
	assign hall_a    = hall_lines_q[0];
	assign hall_b    = hall_lines_q[1];
	assign hall_c    = hall_lines_q[2];
	assign phase_now = phase_q;

`ifndef SYNTH
	// A hold word leaves counters and phase untouched
	a_hold_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && !advance) |=> ($stable(hall_count_q) && $stable(phase_q)
		&& $stable(pwm_count_q)))
		else $error("hold word changed state");

	// A phase change latches the pattern of the phase it left
	a_phase_latch: assert property (@(posedge clk) disable iff (!arst_n)
		(tick && phase_step) |=> (hall_lines_q == hse_pkg::hall_latch($past(phase_q))))
		else $error("hall lines do not match the phase left");

	// A pending result is only retired when taken or replaced
	a_result_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> (out_valid_q && $stable(phase_q)
		&& $stable(hall_lines_q) && $stable(pwm_line_q)))
		else $error("pending result lost or changed");
`endif

endmodule

`default_nettype wire

@@ tb/hall_sensor_emulator_pwm_tb.sv @@
// Testbench for the six-step hall sensor emulator with PWM output.
// Drives tick words and register writes; checks each result word, typed in or predicted.
// Depends on hse_pkg and hall_sensor_emulator_pwm.
`default_nettype none

module hall_sensor_emulator_pwm_tb;

	localparam int CW           = hse_pkg::COUNT_WIDTH_DEFAULT;
	localparam int RANDOM_ITEMS = 1750;
	localparam int RUN_LIMIT    = 100000;
	localparam int STEADY_FROM  = 600;
	localparam int STEADY_TO    = 900;

	// Index past the last register: the block must ignore a write to it
	localparam logic [hse_pkg::CFG_INDEX_WIDTH-1:0] CFG_UNUSED = 2'd3;

	// One result word, field by field
	typedef struct packed {
		logic            lvl;
		logic            ha;
		logic            hb;
		logic            hc;
		hse_pkg::phase_t ph;
	} hall_word_t;

	typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;

	// Directed row: a register write or a tick word, with an optional typed-in result
	typedef struct packed {
		row_kind_t                           kind;
		logic [hse_pkg::CFG_INDEX_WIDTH-1:0] reg_idx;
		logic [hse_pkg::CFG_WIDTH-1:0]       reg_val;
		logic                                adv;
		logic                                typed;
		hall_word_t                          want;
	} plan_row_t;

	localparam int PLAN_ROWS = 30;

	// Lines latched when the sequencer leaves a phase: bit0 A, bit1 B, bit2 C
	localparam logic [2:0] LATCH_ON_LEAVE [0:5] = '{3'b001, 3'b011, 3'b010,
		3'b110, 3'b100, 3'b101};

	localparam plan_row_t PLAN [0:PLAN_ROWS-1] = '{
		// Fresh out of reset: report only, then one tick at reset settings
		'{ROW_TICK,  '0, '0, 1'b0, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, hse_pkg::PHASE_5}},
		'{ROW_TICK,  '0, '0, 1'b1, 1'b1, '{1'b1, 1'b0, 1'b0, 1'b0, hse_pkg::PHASE_5}},
		// Shortest hall cycle that still steps every phase, PWM period of one, no high time
		'{ROW_WRITE, hse_pkg::CFG_HALL_CYCLE, 16'd6, 1'b0, 1'b0, '0},
		'{ROW_WRITE, hse_pkg::CFG_PWM_CYCLE,  16'd1, 1'b0, 1'b0, '0},
		'{ROW_WRITE, hse_pkg::CFG_PWM_HIGH,   16'd0, 1'b0, 1'b0, '0},
		// Walk the sequencer through all six phases
		'{ROW_TICK,  '0, '0, 1'b1, 1'b0, '0},
		'{ROW_TICK,  '0, '0, 1'b1, 1'b0, '0},
		'{ROW_TICK,  '0, '0, 1'b1, 1'b0, '0},
		'{ROW_TICK,  '0, '0, 1'b1, 1'b0, '0},
		'{ROW_TICK,  '0, '0, 1'b1, 1'b0, '0},
		'{ROW_TICK,  '0, '0, 1'b1, 1'b0, '0},
		'{ROW_TICK,  '0, '0, 1'b1, 1'b0, '0},
		'{ROW_TICK,  '0, '0, 1'b1, 1'b0, '0},
		'{ROW_TICK,  '0, '0, 1'b1, 1'b0, '0},
		'{ROW_TICK,  '0, '0, 1'b1, 1'b0, '0},
		'{ROW_TICK,  '0, '0, 1'b0, 1'b0, '0},
		// Zero periods on both counters, full high time: PWM stuck high, phase stuck
		'{ROW_WRITE, hse_pkg::CFG_PWM_CYCLE,  16'd0,     1'b0, 1'b0, '0},
		'{ROW_WRITE, hse_pkg::CFG_PWM_HIGH,   16'hFFFF,  1'b0, 1'b0, '0},
		'{ROW_WRITE, hse_pkg::CFG_HALL_CYCLE, 16'd0,     1'b0, 1'b0, '0},
		'{ROW_TICK,  '0, '0, 1'b1, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b1, hse_pkg::PHASE_0}},
		'{ROW_TICK,  '0, '0, 1'b1, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b1, hse_pkg::PHASE_0}},
		// Largest periods
		'{ROW_WRITE, hse_pkg::CFG_HALL_CYCLE, 16'hFFFF,  1'b0, 1'b0, '0},
		'{ROW_WRITE, hse_pkg::CFG_PWM_CYCLE,  16'hFFFF,  1'b0, 1'b0, '0},
		'{ROW_TICK,  '0, '0, 1'b1, 1'b0, '0},
		'{ROW_TICK,  '0, '0, 1'b1, 1'b0, '0},
		// Hall period below six: the first threshold wraps and phase 0 stalls
		'{ROW_WRITE, hse_pkg::CFG_HALL_CYCLE, 16'd5,     1'b0, 1'b0, '0},
		'{ROW_TICK,  '0, '0, 1'b1, 1'b0, '0},
		'{ROW_TICK,  '0, '0, 1'b1, 1'b0, '0},
		'{ROW_TICK,  '0, '0, 1'b1, 1'b0, '0},
		'{ROW_TICK,  '0, '0, 1'b0, 1'b0, '0}
	};

	logic clk;
	logic arst_n = 1'b0;

	logic                                in_valid  = 1'b0;
	logic                                in_ready;
	logic                                advance   = 1'b0;
	logic                                out_valid;
	logic                                out_ready = 1'b0;
	logic                                pwm_level;
	logic                                hall_a;
	logic                                hall_b;
	logic                                hall_c;
	logic [hse_pkg::PHASE_WIDTH-1:0]     phase_now;
	logic                                cfg_valid = 1'b0;
	logic                                cfg_ready;
	logic [hse_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = '0;
	logic [hse_pkg::CFG_WIDTH-1:0]       cfg_data  = '0;

	// Typed-in result that travels with the tick word on the wire
	logic       word_typed = 1'b0;
	hall_word_t word_want  = '0;

	// Shadow of the block: registers and state at their reset values
	logic [hse_pkg::CFG_WIDTH-1:0] hall_len  = hse_pkg::HALL_CYCLE_RESET;
	logic [hse_pkg::CFG_WIDTH-1:0] pwm_len   = hse_pkg::PWM_CYCLE_RESET;
	logic [hse_pkg::CFG_WIDTH-1:0] pwm_high  = hse_pkg::PWM_HIGH_RESET;
	logic [CW-1:0]                 pwm_cnt   = '0;
	logic [CW-1:0]                 hall_cnt  = '0;
	hse_pkg::phase_t               seq_phase = hse_pkg::PHASE_5;
	logic [2:0]                    seq_lines = 3'b000;
	logic                          pwm_out   = 1'b0;

	hall_word_t  expected_words [$];
	int unsigned mismatches = 0;
	int unsigned cycles     = 0;
	bit          steady     = 1'b0;

	hall_sensor_emulator_pwm #(
		.COUNT_WIDTH(CW)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.advance   (advance),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.pwm_level (pwm_level),
		.hall_a    (hall_a),
		.hall_b    (hall_b),
		.hall_c    (hall_c),
		.phase_now (phase_now),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Count up, clear on reaching the period; the counter width wraps on its own
	function automatic logic [CW-1:0] wrap_count(input logic [CW-1:0] cnt,
			input logic [hse_pkg::CFG_WIDTH-1:0] period);
		logic [CW-1:0] nxt;
		nxt = cnt + 1'b1;
		return (nxt >= period) ? '0 : nxt;
	endfunction

	// Advance the shadow by one tick word and return the result word it gives
	function automatic hall_word_t tick_shadow(input logic adv);
		int unsigned p;
		int unsigned thr;
		logic [CW-1:0] match_at;
		p = hall_len;
		if (adv) begin
			pwm_cnt  = wrap_count(pwm_cnt, pwm_len);
			pwm_out  = (pwm_cnt < pwm_high);
			hall_cnt = wrap_count(hall_cnt, hall_len);
			case (seq_phase)
				hse_pkg::PHASE_0: thr = p / 6;
				hse_pkg::PHASE_1: thr = p / 3;
				hse_pkg::PHASE_2: thr = p / 2;
				hse_pkg::PHASE_3: thr = (p / 3) * 2;
				hse_pkg::PHASE_4: thr = p / 2 + p / 3;
				default:          thr = p;
			endcase
			// A zero threshold wraps to all ones and is never matched
			match_at = CW'(thr - 1);
			if (hall_cnt == match_at) begin
				seq_lines = LATCH_ON_LEAVE[seq_phase];
				seq_phase = (seq_phase == hse_pkg::PHASE_5) ? hse_pkg::PHASE_0
				            : seq_phase + 1'b1;
			end
		end
		return '{pwm_out, seq_lines[0], seq_lines[1], seq_lines[2], seq_phase};
	endfunction

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
		end
	endtask

	// Watch all three channels at every edge. Check the result side first:
	// a word answered at this edge was accepted at an earlier one.
	always @(posedge clk) begin : watch
		hall_word_t got;
		hall_word_t want;
		if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				hse_pkg::CFG_HALL_CYCLE: hall_len = cfg_data;
				hse_pkg::CFG_PWM_CYCLE:  pwm_len  = cfg_data;
				hse_pkg::CFG_PWM_HIGH:   pwm_high = cfg_data;
				default: ;
			endcase
		end
		if (out_valid && out_ready) begin
			got = '{pwm_level, hall_a, hall_b, hall_c, phase_now};
			if (expected_words.size() == 0) begin
				mismatches++;
				$display("%0t: result word with none expected, expected none actual %h",
					$time, got);
			end else begin
				want = expected_words.pop_front();
				check_field("pwm_level", want.lvl, got.lvl);
				check_field("hall_a", want.ha, got.ha);
				check_field("hall_b", want.hb, got.hb);
				check_field("hall_c", want.hc, got.hc);
				check_field("phase_now", want.ph, got.ph);
			end
		end
		if (in_valid && in_ready) begin
			want = tick_shadow(advance);
			expected_words.push_back(word_typed ? word_want : want);
		end
	end

	// Stall the result side at random with a chance of 7 in 100, never during the steady stretch
	always @(posedge clk) begin
		out_ready <= steady || ($urandom_range(0, 99) >= 7);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
	end

	initial begin
		wait (cycles >= RUN_LIMIT);
		$display("Simulation FAILED");
		$finish;
	end

	// Offer one tick word, maybe after a gap with valid low; leave valid high on return
	task automatic send_tick(input logic adv, input logic typed, input hall_word_t want);
		int gap;
		gap = 0;
		if (!steady && $urandom_range(0, 99) < 7) begin
			gap = 1;
		end
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		advance    <= adv;
		word_typed <= typed;
		word_want  <= want;
		do @(posedge clk); while (!in_ready);
	endtask

	// Drop valid and hold until every outstanding result word has come back
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_words.size() != 0) @(posedge clk);
	endtask

	// Write a register with the block idle
	task automatic write_reg(input logic [hse_pkg::CFG_INDEX_WIDTH-1:0] idx,
			input logic [hse_pkg::CFG_WIDTH-1:0] val);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		int          sent;
		int          span;
		int          cur_cycle;
		logic [15:0] val;
		sent      = 0;
		cur_cycle = hse_pkg::PWM_CYCLE_RESET;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part: walk the table
		for (int i = 0; i < PLAN_ROWS; i++) begin
			if (PLAN[i].kind == ROW_WRITE) begin
				write_reg(PLAN[i].reg_idx, PLAN[i].reg_val);
				if (PLAN[i].reg_idx == hse_pkg::CFG_PWM_CYCLE) cur_cycle = PLAN[i].reg_val;
			end else begin
				send_tick(PLAN[i].adv, PLAN[i].typed, PLAN[i].want);
			end
		end

		// Random part: settle a setting, then run a burst of ticks under it.
		// Short hall periods dominate so the sequencer keeps turning.
		while (sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 9) < 7) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4: val = 16'(6 * $urandom_range(1, 12));
					5, 6:          val = 16'($urandom_range(0, 40));
					7:             val = 16'hFFFF;
					8:             val = 16'($urandom_range(0, 65535));
					default:       val = 16'(6 * $urandom_range(13, 300));
				endcase
				write_reg(hse_pkg::CFG_HALL_CYCLE, val);
			end
			if ($urandom_range(0, 9) < 6) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5: val = 16'($urandom_range(1, 20));
					6:                val = 16'd0;
					7:                val = 16'hFFFF;
					8:                val = 16'($urandom_range(0, 65535));
					default:          val = 16'd1;
				endcase
				write_reg(hse_pkg::CFG_PWM_CYCLE, val);
				cur_cycle = val;
			end
			if ($urandom_range(0, 9) < 6) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5, 6: val = 16'($urandom_range(0, cur_cycle + 2));
					7:                   val = 16'd0;
					8:                   val = 16'hFFFF;
					default:             val = 16'($urandom_range(0, 65535));
				endcase
				write_reg(hse_pkg::CFG_PWM_HIGH, val);
			end
			if ($urandom_range(0, 19) == 0) begin
				write_reg(CFG_UNUSED, 16'($urandom_range(0, 65535)));
			end
			span = $urandom_range(20, 160);
			repeat (span) begin
				steady = (sent >= STEADY_FROM && sent < STEADY_TO);
				send_tick($urandom_range(0, 99) < 85, 1'b0, '0);
				sent++;
			end
		end
		steady = 1'b0;

		// Let the last word come back, then give the registered result some slack
		drain();
		repeat (4) @(posedge clk);
		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire

@@ sim.f @@
rtl/core/hse_pkg.sv
rtl/core/hall_sensor_emulator_pwm.sv
tb/hall_sensor_emulator_pwm_tb.sv
